/* rtl/core/vmc_pkg.sv */
// Shared widths, types and constants for the look-at view matrix pipeline.
`timescale 1ns / 1ps

package vmc_pkg;

  // Fixed-point format of every matrix entry.
  localparam int FRAC_BITS = 16;

  // Signed width of one normalized component (magnitude reaches 1.0).
  localparam int NW = FRAC_BITS + 2;
  // Signed width of the vectors that enter a normalize unit.
  localparam int VEC_W = 32 + NW + 1;
  // Width of a component magnitude.
  localparam int MAG_W = VEC_W;
  // Byte chunks used by the leading-one search.
  localparam int NCH = (MAG_W + 7) / 8;
  localparam int CH_W = $clog2(NCH);
  localparam int P_W = CH_W + 3;
  // The largest scaled magnitude lies in [2^29, 2^30).
  localparam int M_W = 30;
  localparam int NORM_MSB = M_W - 1;
  // Sum of three squares and the square-root datapath.
  localparam int S_W = 2 * M_W + 2;
  localparam int SQ_STEPS = M_W + 1;
  localparam int L_W = M_W + 1;
  // Quotient bits and numerator width of the divide steps.
  localparam int QB = FRAC_BITS + 1;
  localparam int DN_W = M_W + FRAC_BITS + 1;
  localparam int R_W = L_W + 1;
  // Product widths of the cross and dot products.
  localparam int PROD_W = 32 + NW;
  localparam int DOT_W = PROD_W + 2;

  typedef logic signed [31:0] fix_t;
  typedef logic signed [NW-1:0] nvec_t;
  typedef logic signed [VEC_W-1:0] wvec_t;
  typedef logic [MAG_W-1:0] mag_t;

  // Column that carries the translation.
  localparam logic [1:0] LAST_COL = 2'd3;
  localparam fix_t ONE_FIX = fix_t'(1) << FRAC_BITS;

  // Per-camera data that rides alongside a normalize unit.
  typedef struct packed {
    logic [2:0][31:0]   eye;
    logic [2:0][31:0]   up;
    logic [2:0][NW-1:0] zv;
    logic [2:0][NW-1:0] xv;
    logic               deg;
  } side_t;

endpackage

/* rtl/core/vmc_norm.sv */
// Pipelined vector normalize: scale, sum of squares, root and three dividers.
`timescale 1ns / 1ps

module vmc_norm
  import vmc_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  adv,
  input  logic  in_valid,
  input  wvec_t in_vec [3],
  input  side_t in_side,
  output logic  out_valid,
  output nvec_t out_vec [3],
  output logic  out_zero,
  output side_t out_side
);

  // Stage a: magnitudes and signs.
  logic       a_valid;
  mag_t       a_mag [3];
  logic [2:0] a_neg;
  side_t      a_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        a_neg[i] <= in_vec[i][VEC_W-1];
        a_mag[i] <= in_vec[i][VEC_W-1] ? mag_t'(-in_vec[i]) : mag_t'(in_vec[i]);
      end
      a_side <= in_side;
    end
  end

  // Stage b: leading one inside each byte of the OR of the magnitudes.
  logic [NCH*8-1:0] orp;
  logic [NCH-1:0]   b_nz_c;
  logic [2:0]       b_pos_c [NCH];

  always_comb begin
    orp = '0;
    orp[MAG_W-1:0] = a_mag[0] | a_mag[1] | a_mag[2];
    for (int j = 0; j < NCH; j++) begin
      b_nz_c[j] = |orp[j*8 +: 8];
      b_pos_c[j] = 3'd0;
      for (int k = 0; k < 8; k++) begin
        if (orp[j*8+k]) begin
          b_pos_c[j] = 3'(k);
        end
      end
    end
  end

  logic           b_valid;
  logic [NCH-1:0] b_nz;
  logic [2:0]     b_pos [NCH];
  mag_t           b_mag [3];
  logic [2:0]     b_neg;
  side_t          b_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (adv) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_nz <= b_nz_c;
      b_pos <= b_pos_c;
      b_mag <= a_mag;
      b_neg <= a_neg;
      b_side <= a_side;
    end
  end

  // Stage c: highest nonzero byte gives the leading-one position.
  logic [P_W-1:0] c_p_c;
  logic           c_zero_c;

  always_comb begin
    c_p_c = '0;
    c_zero_c = 1'b1;
    for (int j = 0; j < NCH; j++) begin
      if (b_nz[j]) begin
        c_p_c = {CH_W'(j), b_pos[j]};
        c_zero_c = 1'b0;
      end
    end
  end

  logic           c_valid;
  logic [P_W-1:0] c_p;
  logic           c_zero;
  mag_t           c_mag [3];
  logic [2:0]     c_neg;
  side_t          c_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (adv) begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_p <= c_p_c;
      c_zero <= c_zero_c;
      c_mag <= b_mag;
      c_neg <= b_neg;
      c_side <= b_side;
    end
  end

  // Stage d: shift so that the largest magnitude lands in [2^29, 2^30).
  localparam logic [P_W-1:0] MSB_POS = P_W'(NORM_MSB);

  mag_t d_sh_c [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (c_p >= MSB_POS) begin
        d_sh_c[i] = c_mag[i] >> (c_p - MSB_POS);
      end else begin
        d_sh_c[i] = c_mag[i] << (MSB_POS - c_p);
      end
    end
  end

  logic           d_valid;
  logic [M_W-1:0] d_m [3];
  logic           d_zero;
  logic [2:0]     d_neg;
  side_t          d_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (adv) begin
      d_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        d_m[i] <= d_sh_c[i][M_W-1:0];
      end
      d_zero <= c_zero;
      d_neg <= c_neg;
      d_side <= c_side;
    end
  end

  // Stage e: squares.
  logic             e_valid;
  logic [2*M_W-1:0] e_sq [3];
  logic [M_W-1:0]   e_m [3];
  logic             e_zero;
  logic [2:0]       e_neg;
  side_t            e_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (adv) begin
      e_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        e_sq[i] <= d_m[i] * d_m[i];
      end
      e_m <= d_m;
      e_zero <= d_zero;
      e_neg <= d_neg;
      e_side <= d_side;
    end
  end

  // Square root: entry 0 holds the sum, then one result bit per stage.
  logic           sr_valid [SQ_STEPS+1];
  logic [S_W-1:0] sr_s [SQ_STEPS+1];
  logic [S_W-1:0] sr_res [SQ_STEPS+1];
  logic [M_W-1:0] sr_m [SQ_STEPS+1][3];
  logic           sr_zero [SQ_STEPS+1];
  logic [2:0]     sr_neg [SQ_STEPS+1];
  side_t          sr_side [SQ_STEPS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      sr_valid[0] <= 1'b0;
    end else if (adv) begin
      sr_valid[0] <= e_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sr_s[0] <= S_W'(e_sq[0]) + S_W'(e_sq[1]) + S_W'(e_sq[2]);
      sr_res[0] <= '0;
      sr_m[0] <= e_m;
      sr_zero[0] <= e_zero;
      sr_neg[0] <= e_neg;
      sr_side[0] <= e_side;
    end
  end

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    localparam logic [S_W-1:0] BIT = S_W'(1) << (2 * (SQ_STEPS - 1 - k));
    logic [S_W-1:0] trial;

    assign trial = sr_res[k] + BIT;

    always_ff @(posedge clk) begin
      if (rst) begin
        sr_valid[k+1] <= 1'b0;
      end else if (adv) begin
        sr_valid[k+1] <= sr_valid[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        if (sr_s[k] >= trial) begin
          sr_s[k+1] <= sr_s[k] - trial;
          sr_res[k+1] <= (sr_res[k] >> 1) + BIT;
        end else begin
          sr_s[k+1] <= sr_s[k];
          sr_res[k+1] <= sr_res[k] >> 1;
        end
        sr_m[k+1] <= sr_m[k];
        sr_zero[k+1] <= sr_zero[k];
        sr_neg[k+1] <= sr_neg[k];
        sr_side[k+1] <= sr_side[k];
      end
    end
  end

  // Divide: entry 0 holds the rounded numerators, then one quotient bit per stage.
  logic            dv_valid [QB+1];
  logic [DN_W-1:0] dv_n [QB+1][3];
  logic [R_W-1:0]  dv_r [QB+1][3];
  logic [QB-1:0]   dv_q [QB+1][3];
  logic [L_W-1:0]  dv_l [QB+1];
  logic            dv_zero [QB+1];
  logic [2:0]      dv_neg [QB+1];
  side_t           dv_side [QB+1];

  logic [L_W-1:0]  len;
  logic [DN_W-1:0] num_c [3];

  always_comb begin
    len = sr_res[SQ_STEPS][L_W-1:0];
    for (int i = 0; i < 3; i++) begin
      num_c[i] = DN_W'({sr_m[SQ_STEPS][i], {FRAC_BITS{1'b0}}}) + DN_W'(len >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_valid[0] <= 1'b0;
    end else if (adv) begin
      dv_valid[0] <= sr_valid[SQ_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        dv_n[0][i] <= num_c[i];
        dv_r[0][i] <= R_W'(num_c[i] >> QB);
        dv_q[0][i] <= '0;
      end
      dv_l[0] <= len;
      dv_zero[0] <= sr_zero[SQ_STEPS];
      dv_neg[0] <= sr_neg[SQ_STEPS];
      dv_side[0] <= sr_side[SQ_STEPS];
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_div
    logic [R_W-1:0] part [3];
    logic [2:0]     ge;

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        part[i] = {dv_r[k][i][R_W-2:0], dv_n[k][i][QB-1-k]};
        ge[i] = part[i] >= {1'b0, dv_l[k]};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_valid[k+1] <= 1'b0;
      end else if (adv) begin
        dv_valid[k+1] <= dv_valid[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        for (int i = 0; i < 3; i++) begin
          dv_r[k+1][i] <= ge[i] ? part[i] - {1'b0, dv_l[k]} : part[i];
          dv_q[k+1][i] <= {dv_q[k][i][QB-2:0], ge[i]};
          dv_n[k+1][i] <= dv_n[k][i];
        end
        dv_l[k+1] <= dv_l[k];
        dv_zero[k+1] <= dv_zero[k];
        dv_neg[k+1] <= dv_neg[k];
        dv_side[k+1] <= dv_side[k];
      end
    end
  end

  // Output stage: apply signs, force zero for a zero-length vector.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= dv_valid[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        if (dv_zero[QB]) begin
          out_vec[i] <= '0;
        end else if (dv_neg[QB][i]) begin
          out_vec[i] <= -nvec_t'({1'b0, dv_q[QB][i]});
        end else begin
          out_vec[i] <= nvec_t'({1'b0, dv_q[QB][i]});
        end
      end
      out_zero <= dv_zero[QB];
      out_side <= dv_side[QB];
    end
  end

endmodule

/* rtl/core/view_matrix_from_camera_top.sv */
// Top level of the look-at view matrix pipeline with its column serializer.
`timescale 1ns / 1ps

// Takes one camera (eye, target, up in signed Q16.16) and returns the 4x4 view
// matrix as four words, one column per word, column 3 last with last_column set.
// The datapath is a single stall-together pipeline of about 180 register stages
// (three normalize units of 56 stages each, plus cross, dot and rounding stages).
// The column serializer at the end emits one word per cycle while out_stall is low,
// which sets the sustained rate at one camera every four words; in_stall rises
// only while the last pipeline stage holds a finished camera that the serializer
// cannot yet take. degenerate is set on all four columns when any basis vector
// had zero length.
module view_matrix_from_camera_top
  import vmc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  fix_t       eye_x,
  input  fix_t       eye_y,
  input  fix_t       eye_z,
  input  fix_t       target_x,
  input  fix_t       target_y,
  input  fix_t       target_z,
  input  fix_t       up_x,
  input  fix_t       up_y,
  input  fix_t       up_z,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] column_index,
  output fix_t       entry_row0,
  output fix_t       entry_row1,
  output fix_t       entry_row2,
  output fix_t       entry_row3,
  output logic       last_column,
  output logic       degenerate
);

  typedef struct packed {
    logic [2:0][NW-1:0] xv;
    logic [2:0][NW-1:0] yv;
    logic [2:0][NW-1:0] zv;
    logic               deg;
  } mat_t;

  localparam logic [DOT_W-1:0] RND_HALF = DOT_W'(1) << (FRAC_BITS - 1);
  localparam int TW = DOT_W + 1;

  logic adv;
  logic take;
  logic dt_valid;
  logic ser_valid;
  logic [1:0] ser_col;
  logic out_fire;

  assign out_fire = out_valid && !out_stall;
  assign take = dt_valid && (!ser_valid || (out_fire && ser_col == LAST_COL));
  assign adv = !dt_valid || take;
  assign in_stall = !adv;

  // Entry stage: view direction eye - target.
  logic  t0_valid;
  wvec_t t0_d [3];
  side_t t0_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      t0_valid <= 1'b0;
    end else if (adv) begin
      t0_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t0_d[0] <= wvec_t'(eye_x) - wvec_t'(target_x);
      t0_d[1] <= wvec_t'(eye_y) - wvec_t'(target_y);
      t0_d[2] <= wvec_t'(eye_z) - wvec_t'(target_z);
      t0_side.eye <= {eye_z, eye_y, eye_x};
      t0_side.up <= {up_z, up_y, up_x};
      t0_side.zv <= '0;
      t0_side.xv <= '0;
      t0_side.deg <= 1'b0;
    end
  end

  // z axis.
  logic  n1_valid;
  nvec_t n1_vec [3];
  logic  n1_zero;
  side_t n1_side;

  vmc_norm u_norm_z (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (t0_valid),
    .in_vec    (t0_d),
    .in_side   (t0_side),
    .out_valid (n1_valid),
    .out_vec   (n1_vec),
    .out_zero  (n1_zero),
    .out_side  (n1_side)
  );

  // Products of cross(up, z).
  logic                     c1p_valid;
  logic signed [PROD_W-1:0] c1p_p [6];
  side_t                    c1p_side;
  side_t                    s1_c;

  always_comb begin
    s1_c = n1_side;
    for (int i = 0; i < 3; i++) begin
      s1_c.zv[i] = n1_vec[i];
    end
    s1_c.deg = n1_zero;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c1p_valid <= 1'b0;
    end else if (adv) begin
      c1p_valid <= n1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c1p_p[0] <= PROD_W'($signed(n1_side.up[1]) * n1_vec[2]);
      c1p_p[1] <= PROD_W'($signed(n1_side.up[2]) * n1_vec[1]);
      c1p_p[2] <= PROD_W'($signed(n1_side.up[2]) * n1_vec[0]);
      c1p_p[3] <= PROD_W'($signed(n1_side.up[0]) * n1_vec[2]);
      c1p_p[4] <= PROD_W'($signed(n1_side.up[0]) * n1_vec[1]);
      c1p_p[5] <= PROD_W'($signed(n1_side.up[1]) * n1_vec[0]);
      c1p_side <= s1_c;
    end
  end

  // Differences of cross(up, z).
  logic  c1d_valid;
  wvec_t c1d_c [3];
  side_t c1d_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      c1d_valid <= 1'b0;
    end else if (adv) begin
      c1d_valid <= c1p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        c1d_c[i] <= wvec_t'(c1p_p[2*i]) - wvec_t'(c1p_p[2*i+1]);
      end
      c1d_side <= c1p_side;
    end
  end

  // x axis.
  logic  n2_valid;
  nvec_t n2_vec [3];
  logic  n2_zero;
  side_t n2_side;

  vmc_norm u_norm_x (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (c1d_valid),
    .in_vec    (c1d_c),
    .in_side   (c1d_side),
    .out_valid (n2_valid),
    .out_vec   (n2_vec),
    .out_zero  (n2_zero),
    .out_side  (n2_side)
  );

  // Products of cross(z, x).
  logic                     c2p_valid;
  logic signed [PROD_W-1:0] c2p_p [6];
  side_t                    c2p_side;
  side_t                    s2_c;
  nvec_t                    zc [3];

  always_comb begin
    s2_c = n2_side;
    for (int i = 0; i < 3; i++) begin
      s2_c.xv[i] = n2_vec[i];
      zc[i] = nvec_t'(n2_side.zv[i]);
    end
    s2_c.deg = n2_side.deg | n2_zero;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c2p_valid <= 1'b0;
    end else if (adv) begin
      c2p_valid <= n2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c2p_p[0] <= PROD_W'(zc[1] * n2_vec[2]);
      c2p_p[1] <= PROD_W'(zc[2] * n2_vec[1]);
      c2p_p[2] <= PROD_W'(zc[2] * n2_vec[0]);
      c2p_p[3] <= PROD_W'(zc[0] * n2_vec[2]);
      c2p_p[4] <= PROD_W'(zc[0] * n2_vec[1]);
      c2p_p[5] <= PROD_W'(zc[1] * n2_vec[0]);
      c2p_side <= s2_c;
    end
  end

  // Differences of cross(z, x).
  logic  c2d_valid;
  wvec_t c2d_c [3];
  side_t c2d_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      c2d_valid <= 1'b0;
    end else if (adv) begin
      c2d_valid <= c2p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        c2d_c[i] <= wvec_t'(c2p_p[2*i]) - wvec_t'(c2p_p[2*i+1]);
      end
      c2d_side <= c2p_side;
    end
  end

  // y axis.
  logic  n3_valid;
  nvec_t n3_vec [3];
  logic  n3_zero;
  side_t n3_side;

  vmc_norm u_norm_y (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (c2d_valid),
    .in_vec    (c2d_c),
    .in_side   (c2d_side),
    .out_valid (n3_valid),
    .out_vec   (n3_vec),
    .out_zero  (n3_zero),
    .out_side  (n3_side)
  );

  // Dot products with the eye point, one row per basis vector.
  logic                     dp_valid;
  logic signed [PROD_W-1:0] dp_p [3][3];
  mat_t                     dp_m;

  always_ff @(posedge clk) begin
    if (rst) begin
      dp_valid <= 1'b0;
    end else if (adv) begin
      dp_valid <= n3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        dp_p[0][i] <= PROD_W'($signed(n3_side.xv[i]) * $signed(n3_side.eye[i]));
        dp_p[1][i] <= PROD_W'(n3_vec[i] * $signed(n3_side.eye[i]));
        dp_p[2][i] <= PROD_W'($signed(n3_side.zv[i]) * $signed(n3_side.eye[i]));
        dp_m.yv[i] <= n3_vec[i];
      end
      dp_m.xv <= n3_side.xv;
      dp_m.zv <= n3_side.zv;
      dp_m.deg <= n3_side.deg | n3_zero;
    end
  end

  // Row sums.
  logic                    ds_valid;
  logic signed [DOT_W-1:0] ds_s [3];
  mat_t                    ds_m;

  always_ff @(posedge clk) begin
    if (rst) begin
      ds_valid <= 1'b0;
    end else if (adv) begin
      ds_valid <= dp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        ds_s[r] <= DOT_W'(dp_p[r][0]) + DOT_W'(dp_p[r][1]) + DOT_W'(dp_p[r][2]);
      end
      ds_m <= dp_m;
    end
  end

  // Magnitude and sign of each sum.
  logic             da_valid;
  logic [DOT_W-1:0] da_mag [3];
  logic [2:0]       da_neg;
  mat_t             da_m;

  always_ff @(posedge clk) begin
    if (rst) begin
      da_valid <= 1'b0;
    end else if (adv) begin
      da_valid <= ds_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        da_neg[r] <= ds_s[r][DOT_W-1];
        da_mag[r] <= ds_s[r][DOT_W-1] ? DOT_W'(-ds_s[r]) : DOT_W'(ds_s[r]);
      end
      da_m <= ds_m;
    end
  end

  // Round the magnitude to the fraction width, ties away from zero.
  logic             dr_valid;
  logic [DOT_W-1:0] dr_rnd [3];
  logic [2:0]       dr_neg;
  mat_t             dr_m;

  always_ff @(posedge clk) begin
    if (rst) begin
      dr_valid <= 1'b0;
    end else if (adv) begin
      dr_valid <= da_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        dr_rnd[r] <= (da_mag[r] + RND_HALF) >> FRAC_BITS;
      end
      dr_neg <= da_neg;
      dr_m <= da_m;
    end
  end

  // Negate and saturate the translation entries.
  logic signed [TW-1:0] tv [3];
  fix_t                 tsat [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      if (dr_neg[r]) begin
        tv[r] = $signed({1'b0, dr_rnd[r]});
      end else begin
        tv[r] = -$signed({1'b0, dr_rnd[r]});
      end
      if (tv[r][TW-1:31] == '0 || tv[r][TW-1:31] == '1) begin
        tsat[r] = tv[r][31:0];
      end else if (tv[r][TW-1]) begin
        tsat[r] = {1'b1, 31'd0};
      end else begin
        tsat[r] = {1'b0, {31{1'b1}}};
      end
    end
  end

  fix_t dt_t [3];
  mat_t dt_m;

  always_ff @(posedge clk) begin
    if (rst) begin
      dt_valid <= 1'b0;
    end else if (adv) begin
      dt_valid <= dr_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dt_t <= tsat;
      dt_m <= dr_m;
    end
  end

  // Column serializer: one word per column, translation column last.
  fix_t ser_t [3];
  mat_t ser_m;

  always_ff @(posedge clk) begin
    if (rst) begin
      ser_valid <= 1'b0;
      ser_col <= 2'd0;
    end else if (take) begin
      ser_valid <= 1'b1;
      ser_col <= 2'd0;
    end else if (out_fire) begin
      if (ser_col == LAST_COL) begin
        ser_valid <= 1'b0;
      end else begin
        ser_col <= ser_col + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      ser_t <= dt_t;
      ser_m <= dt_m;
    end
  end

  // Output word selection.
  always_comb begin
    case (ser_col)
      LAST_COL: begin
        entry_row0 = ser_t[0];
        entry_row1 = ser_t[1];
        entry_row2 = ser_t[2];
        entry_row3 = ONE_FIX;
      end
      default: begin
        entry_row0 = 32'($signed(ser_m.xv[ser_col]));
        entry_row1 = 32'($signed(ser_m.yv[ser_col]));
        entry_row2 = 32'($signed(ser_m.zv[ser_col]));
        entry_row3 = '0;
      end
    endcase
  end

  assign out_valid = ser_valid;
  assign column_index = ser_col;
  assign last_column = ser_col == LAST_COL;
  assign degenerate = ser_m.deg;

  // After a non-final column leaves, the next column follows at once.
  a_next_col: assert property (@(posedge clk) disable iff (rst)
    out_fire && !last_column |=> out_valid && column_index == $past(column_index) + 2'd1)
    else $error("column sequence broken");

  // The degenerate flag is shared by all columns of one camera.
  a_deg_hold: assert property (@(posedge clk) disable iff (rst)
    out_fire && !last_column |=> degenerate == $past(degenerate))
    else $error("degenerate changed within a matrix");

  // Input is only held back when a finished camera waits at the pipeline end.
  a_no_idle_stall: assert property (@(posedge clk) disable iff (rst)
    !dt_valid |-> !in_stall)
    else $error("input stalled with empty pipeline end");

endmodule
